>>> design/tkhs_pkg.sv
`default_nettype none

package tkhs_pkg;

    // Field widths of one item.
    localparam int IDX_W  = 32;
    localparam int WGT_W  = 32;
    localparam int KEY_W  = WGT_W + IDX_W;
    localparam int KLIM_W = 7;

    // Default capacity and register reset value.
    localparam int              MAX_RECORDS_DEF = 64;
    localparam logic [KLIM_W-1:0] KLIM_RESET    = 7'd64;

    // Input opcodes.
    localparam logic OPC_OFFER = 1'b0;
    localparam logic OPC_DRAIN = 1'b1;

    // Cell operations broadcast along the chain.
    localparam logic [1:0] CELL_HOLD    = 2'd0;
    localparam logic [1:0] CELL_APPEND  = 2'd1;
    localparam logic [1:0] CELL_REPLACE = 2'd2;
    localparam logic [1:0] CELL_SHIFT   = 2'd3;

    // Sort key: weight in the upper half, index in the lower half.
    typedef logic [KEY_W-1:0] key_t;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic [1:0] op;
        logic       live;
        logic       reach;
        logic       first;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> design/top_k_heaviest_selector_top.sv
// Channel   | Handshake           | Payload
// ----------+---------------------+--------------------------------------------
// input     | in_valid / in_ready | opcode, record_index, record_weight
// result    | res_valid/res_ready | out_index, out_weight, out_valid, out_last
// config    | cfg_we              | cfg_wdata (k_limit)
//
// Offers may arrive back to back, and every cell of the chain compares and moves its
// record in the same cycle as the offer is taken.
// A drain first shifts the chain until the heaviest record sits in the last cell, then
// emits one record a cycle while the result register is free or being taken.
// An empty drain gives a single result. Input is not taken during a drain.
// A stalled result holds the output register; while a drain emits, the chain waits.
// Reset (rst_n, asynchronous) empties the store and sets k_limit to 64.
`default_nettype none

module top_k_heaviest_selector_top
    import tkhs_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [KLIM_W-1:0] cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              opcode,
    input  wire logic [IDX_W-1:0]  record_index,
    input  wire logic [WGT_W-1:0]  record_weight,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output logic [IDX_W-1:0]       out_index,
    output logic [WGT_W-1:0]       out_weight,
    output logic                   out_valid,
    output logic                   out_last
);

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int CMP_W = (CNT_W > KLIM_W) ? CNT_W : KLIM_W;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic              state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  gap_reg, gap_next;
    logic [KLIM_W-1:0] k_limit_reg;
    logic              res_valid_reg, res_valid_next;
    logic [IDX_W-1:0]  out_index_reg, out_index_next;
    logic [WGT_W-1:0]  out_weight_reg, out_weight_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_last_reg, out_last_next;

    logic [1:0]        cell_op;
    logic              in_fire;
    logic              slot_free;
    logic              append_ok;
    logic [WGT_W-1:0]  min_weight;
    key_t              new_key;

    // Chain links, padded with a fixed neighbor at each end.
    key_t pad_key [0:MAX_RECORDS+1];
    logic pad_lt  [0:MAX_RECORDS+1];

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !res_valid_reg || res_ready;
    assign new_key   = {record_weight, record_index};
    assign min_weight = pad_key[1][KEY_W-1:IDX_W];

    // Room to append while below both the register limit and the capacity.
    assign append_ok = (CMP_W'(count_reg) < CMP_W'(k_limit_reg))
                    && (CMP_W'(count_reg) < CMP_W'(MAX_RECORDS));

    assign pad_key[0]             = '0;
    assign pad_lt[0]              = 1'b1;
    assign pad_key[MAX_RECORDS+1] = '0;
    assign pad_lt[MAX_RECORDS+1]  = 1'b0;

    // Row of cells, lightest record in cell 0.
    for (genvar i = 0; i < MAX_RECORDS; i++)
    begin : g_cell
        cell_ctrl_t ctrl;

        assign ctrl.op    = cell_op;
        assign ctrl.live  = CNT_W'(i) < count_reg;
        assign ctrl.reach = CNT_W'(i) <= count_reg;
        assign ctrl.first = (i == 0);

        tkhs_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .new_key   (new_key),
            .below_key (pad_key[i]),
            .below_lt  (pad_lt[i]),
            .above_key (pad_key[i+2]),
            .above_lt  (pad_lt[i+2]),
            .key       (pad_key[i+1]),
            .lt        (pad_lt[i+1])
        );
    end

    // Sequencer for offers and drains.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        gap_next        = gap_reg;
        cell_op         = CELL_HOLD;
        res_valid_next  = res_valid_reg && !res_ready;
        out_index_next  = out_index_reg;
        out_weight_next = out_weight_reg;
        out_valid_next  = out_valid_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (opcode == OPC_DRAIN)
                    begin
                        state_next = ST_DRAIN;
                        gap_next   = CNT_W'(MAX_RECORDS) - count_reg;
                    end
                    else if (append_ok)
                    begin
                        cell_op    = CELL_APPEND;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else if ((count_reg != '0) && !(min_weight > record_weight))
                    begin
                        cell_op = CELL_REPLACE;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (count_reg == '0)
                begin
                    // Empty store: one invalid result.
                    if (slot_free)
                    begin
                        res_valid_next  = 1'b1;
                        out_index_next  = '0;
                        out_weight_next = '0;
                        out_valid_next  = 1'b0;
                        out_last_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else if (gap_reg != '0)
                begin
                    // Move the records up until the heaviest is in the last cell.
                    cell_op  = CELL_SHIFT;
                    gap_next = gap_reg - CNT_W'(1);
                end
                else if (slot_free)
                begin
                    cell_op         = CELL_SHIFT;
                    res_valid_next  = 1'b1;
                    out_index_next  = pad_key[MAX_RECORDS][IDX_W-1:0];
                    out_weight_next = pad_key[MAX_RECORDS][KEY_W-1:IDX_W];
                    out_valid_next  = 1'b1;
                    out_last_next   = (count_reg == CNT_W'(1));
                    count_next      = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            gap_reg       <= '0;
            k_limit_reg   <= KLIM_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            gap_reg       <= gap_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                k_limit_reg <= cfg_wdata;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        out_index_reg  <= out_index_next;
        out_weight_reg <= out_weight_next;
        out_valid_reg  <= out_valid_next;
        out_last_reg   <= out_last_next;
    end

    assign res_valid  = res_valid_reg;
    assign out_index  = out_index_reg;
    assign out_weight = out_weight_reg;
    assign out_valid  = out_valid_reg;
    assign out_last   = out_last_reg;

endmodule

`default_nettype wire

>>> design/tkhs_cell.sv
`default_nettype none

module tkhs_cell
    import tkhs_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire key_t       new_key,
    input  wire key_t       below_key,
    input  wire logic       below_lt,
    input  wire key_t       above_key,
    input  wire logic       above_lt,
    output key_t            key,
    output logic            lt
);

    key_t key_reg;
    key_t key_next;

    // A held record lighter than the offered key; these form a prefix of the chain.
    assign lt  = ctrl.live && (key_reg < new_key);
    assign key = key_reg;

    // Hold, sorted insert, replace-the-minimum and shift toward the heavy end.
    always_comb
    begin
        key_next = key_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
                key_next = key_reg;
            end
            CELL_APPEND:
            begin
                if (ctrl.reach && !lt)
                begin
                    key_next = below_lt ? new_key : below_key;
                end
            end
            CELL_REPLACE:
            begin
                if (above_lt)
                begin
                    key_next = above_key;
                end
                else if (lt || ctrl.first)
                begin
                    key_next = new_key;
                end
            end
            CELL_SHIFT:
            begin
                key_next = below_key;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

`default_nettype wire

>>> design/tkhs_checker.sv
`default_nettype none

module tkhs_checker
    import tkhs_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              opcode,
    input wire logic              res_valid,
    input wire logic              res_ready,
    input wire logic [IDX_W-1:0]  out_index,
    input wire logic [WGT_W-1:0]  out_weight,
    input wire logic              out_valid,
    input wire logic              out_last
);

    // An empty drain gives a single closing result.
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !out_valid |-> out_last)
        else $error("invalid result without last mark");

    // The empty result carries zero fields.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !out_valid |-> (out_index == '0) && (out_weight == '0))
        else $error("empty result with nonzero fields");

    // No new item is taken right after a drain item.
    a_drain_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == OPC_DRAIN) |=> !in_ready)
        else $error("item accepted during a drain");

    // A stalled result holds its fields.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(out_index)
            && $stable(out_weight) && $stable(out_valid) && $stable(out_last))
        else $error("result changed while stalled");

endmodule

bind top_k_heaviest_selector_top tkhs_checker u_tkhs_checker (.*);

`default_nettype wire
